// ----- src/ztc_pkg.sv -----
package ztc_pkg;

  // Screen coordinates and frame dimensions are 12 bits wide.
  localparam int COORD_W = 12;
  // A linear frame index before the store range check: row * width + column.
  localparam int IDX_W = 2 * COORD_W + 1;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 12;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_MAP_WIDTH    = 3'd2,
    REG_ORIGIN_ROW   = 3'd3,
    REG_DEPTH_TEST   = 3'd4
  } cfg_reg_e;

  // Command codes carried in the command field.
  localparam logic [1:0] CMD_DRAW  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Depth value that a clear leaves behind: the most negative 16-bit depth.
  localparam logic [15:0] DEPTH_CLEAR = 16'h8000;

  typedef struct packed {
    logic [1:0]  command;
    logic [9:0]  cell_col;
    logic [9:0]  cell_row;
    logic [3:0]  cell_level;
    logic [7:0]  tile_origin_x;
    logic [7:0]  tile_origin_y;
    logic [7:0]  tile_px;
    logic [7:0]  tile_py;
    logic [31:0] pixel_rgba;
    logic [7:0]  depth_offset;
    logic [19:0] frame_index;
  } in_t;

  typedef struct packed {
    logic [31:0] read_rgba;
    logic        painted;
    logic        clipped;
  } out_t;

  // Write request into the colour and depth stores.
  typedef struct packed {
    logic        col_we;
    logic        dep_we;
    logic [31:0] rgba;
    logic [15:0] depth;
  } store_wr_t;

endpackage

// ----- src/ztc_store.sv -----
module ztc_store import ztc_pkg::*; #(
  parameter int DEPTH = 1024,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  input  store_wr_t        wr_i,
  input  logic [AddrW-1:0] wr_addr_i,
  output logic [31:0]      col_o,
  output logic [15:0]      dep_o
);

  logic [31:0] col_mem [DEPTH];
  logic [15:0] dep_mem [DEPTH];

  logic [31:0] col_rd_q;
  logic [15:0] dep_rd_q;
  logic [31:0] col_byp_q;
  logic [15:0] dep_byp_q;
  logic        col_hit_q;
  logic        dep_hit_q;

  // Read-first memories: a read in the cycle of a write to the same entry
  // returns the old data, which the bypass registers below then replace.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      col_rd_q <= col_mem[rd_addr_i];
    end
    if (wr_i.col_we) begin
      col_mem[wr_addr_i] <= wr_i.rgba;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      dep_rd_q <= dep_mem[rd_addr_i];
    end
    if (wr_i.dep_we) begin
      dep_mem[wr_addr_i] <= wr_i.depth;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      col_byp_q <= wr_i.rgba;
      dep_byp_q <= wr_i.depth;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_hit_q <= 1'b0;
      dep_hit_q <= 1'b0;
    end else if (rd_en_i) begin
      col_hit_q <= wr_i.col_we && (wr_addr_i == rd_addr_i);
      dep_hit_q <= wr_i.dep_we && (wr_addr_i == rd_addr_i);
    end
  end

  assign col_o = col_hit_q ? col_byp_q : col_rd_q;
  assign dep_o = dep_hit_q ? dep_byp_q : dep_rd_q;

endmodule

// ----- src/zbuffered_iso_tile_compositor_core.sv -----
// Depth-buffered compositor for isometric terrain tile pixels. Each input
// transaction is a draw, clear or read command against a frame store of
// STORE_ENTRIES entries, each holding a 32-bit RGBA colour and a 16-bit signed
// depth; every transaction returns exactly one result transaction. A draw
// places a tile pixel at x = col*CELL_HALF_W minus the tile's x origin plus px
// and y = origin_row + (row - level)*CELL_HALF_H minus the tile's y origin
// plus py, clips it to the frame and to the store, skips it when alpha is
// zero, and otherwise writes it when depth testing is off or when its depth
// (row + map_width + 1) * CELL_H/2 - depth_offset is not below the stored
// depth. The store contents are undefined after reset, so the host must clear
// every entry before it draws to it or reads it. The block accepts one
// transaction per clock while results are taken, and keeps that rate under
// any mix of commands, including back-to-back draws to the same pixel,
// because a write is forwarded to the read that follows it. A transaction
// passes four registers: one stage for screen position and depth, one for
// the row-times-width multiply, one for the store read, and the output
// register. Configuration writes are only legal while no transaction is in
// flight.
module zbuffered_iso_tile_compositor_core import ztc_pkg::*; #(
  parameter int STORE_ENTRIES = 1048576,
  parameter int CELL_HALF_W   = 30,
  parameter int CELL_HALF_H   = 15,
  parameter int CELL_H        = 30
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o
);

  localparam int AddrW = $clog2(STORE_ENTRIES);
  // Signed widths that hold every unclipped screen position with headroom.
  localparam int XW = $clog2(1023 * CELL_HALF_W + 256) + 2;
  localparam int YW = $clog2(1023 * CELL_HALF_H + 4096 + 256) + 2;
  localparam int HalfH = CELL_H / 2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_DRAW,
    OP_CLEAR,
    OP_READ
  } op_e;

  // Configuration registers.
  logic [COORD_W-1:0] frame_width_q;
  logic [COORD_W-1:0] frame_height_q;
  logic [8:0]         map_width_q;
  logic [COORD_W-1:0] origin_row_q;
  logic               depth_test_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= 12'd1024;
      frame_height_q <= 12'd1024;
      map_width_q    <= 9'd0;
      origin_row_q   <= 12'd96;
      depth_test_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        REG_MAP_WIDTH:    map_width_q    <= cfg_wdata_i[8:0];
        REG_ORIGIN_ROW:   origin_row_q   <= cfg_wdata_i;
        REG_DEPTH_TEST:   depth_test_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control. Every stage moves on when the stage after it is
  // empty or moving itself, so bubbles close up and the input keeps being
  // accepted while a result waits in the output register and a stage is empty.
  logic v1_q, v2_q, v3_q, out_valid_q;
  logic take_out, free3, free2, free1, leave3;

  assign take_out   = !out_valid_q || out_ready_i;
  assign free3      = !v3_q || take_out;
  assign free2      = !v2_q || free3;
  assign free1      = !v1_q || free2;
  assign leave3     = v3_q && take_out;
  assign in_ready_o = free1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (free1) begin
        v1_q <= in_valid_i;
      end
      if (free2) begin
        v2_q <= v1_q;
      end
      if (free3) begin
        v3_q <= v2_q;
      end
      if (take_out) begin
        out_valid_q <= v3_q;
      end
    end
  end

  // Stage 1: screen position, frame clipping and depth. Positions are
  // computed modulo 2^XW and 2^YW; the top bit is the sign of the true value.
  logic [XW-1:0]      x_s0;
  logic [YW-1:0]      y_diff_s0;
  logic [YW-1:0]      y_s0;
  logic               clip_s0;
  logic [15:0]        z_s0;

  always_comb begin
    x_s0 = XW'(XW'(in_data_i.cell_col) * XW'(CELL_HALF_W))
         + XW'(in_data_i.tile_px) - XW'(in_data_i.tile_origin_x);
    y_diff_s0 = YW'(in_data_i.cell_row) - YW'(in_data_i.cell_level);
    y_s0 = YW'(origin_row_q) + YW'(y_diff_s0 * YW'(CELL_HALF_H))
         + YW'(in_data_i.tile_py) - YW'(in_data_i.tile_origin_y);
    clip_s0 = x_s0[XW-1] || (x_s0 >= XW'(frame_width_q))
           || y_s0[YW-1] || (y_s0 >= YW'(frame_height_q));
    z_s0 = 16'((16'(in_data_i.cell_row) + 16'd1 + 16'(map_width_q)) * 16'(HalfH))
         - 16'(in_data_i.depth_offset);
  end

  logic [1:0]         cmd1_q;
  logic [COORD_W-1:0] x1_q;
  logic [COORD_W-1:0] y1_q;
  logic               clip1_q;
  logic               opaque1_q;
  logic [31:0]        rgba1_q;
  logic [15:0]        z1_q;
  logic [19:0]        fidx1_q;

  always_ff @(posedge clk_i) begin
    if (free1) begin
      cmd1_q    <= in_data_i.command;
      x1_q      <= x_s0[COORD_W-1:0];
      y1_q      <= y_s0[COORD_W-1:0];
      clip1_q   <= clip_s0;
      opaque1_q <= (in_data_i.pixel_rgba[31:24] != 8'd0);
      rgba1_q   <= in_data_i.pixel_rgba;
      z1_q      <= z_s0;
      fidx1_q   <= in_data_i.frame_index;
    end
  end

  // Stage 2: linear store index. Clear and read take the index directly.
  logic [2*COORD_W-1:0] row_base_s1;
  logic [IDX_W-1:0]     idx_s1;

  always_comb begin
    row_base_s1 = y1_q * frame_width_q;
    if (cmd1_q == CMD_DRAW) begin
      idx_s1 = IDX_W'(row_base_s1) + IDX_W'(x1_q);
    end else begin
      idx_s1 = IDX_W'(fidx1_q);
    end
  end

  logic [1:0]       cmd2_q;
  logic [IDX_W-1:0] idx2_q;
  logic             clip2_q;
  logic             opaque2_q;
  logic [31:0]      rgba2_q;
  logic [15:0]      z2_q;

  always_ff @(posedge clk_i) begin
    if (free2) begin
      cmd2_q    <= cmd1_q;
      idx2_q    <= idx_s1;
      clip2_q   <= clip1_q;
      opaque2_q <= opaque1_q;
      rgba2_q   <= rgba1_q;
      z2_q      <= z1_q;
    end
  end

  // Classification against the store range; the store read is issued here.
  logic in_store_s2;
  op_e  op_s2;
  logic clip_s2;

  always_comb begin
    in_store_s2 = (idx2_q < IDX_W'(STORE_ENTRIES));
    op_s2       = OP_NONE;
    clip_s2     = 1'b0;
    unique case (cmd2_q)
      CMD_DRAW: begin
        if (clip2_q || !in_store_s2) begin
          clip_s2 = 1'b1;
        end else if (opaque2_q) begin
          op_s2 = OP_DRAW;
        end
      end
      CMD_CLEAR: begin
        clip_s2 = !in_store_s2;
        op_s2   = in_store_s2 ? OP_CLEAR : OP_NONE;
      end
      CMD_READ: begin
        clip_s2 = !in_store_s2;
        op_s2   = in_store_s2 ? OP_READ : OP_NONE;
      end
      default: ;
    endcase
  end

  op_e              op3_q;
  logic [AddrW-1:0] addr3_q;
  logic             clip3_q;
  logic [31:0]      rgba3_q;
  logic [15:0]      z3_q;

  always_ff @(posedge clk_i) begin
    if (free3) begin
      op3_q   <= op_s2;
      addr3_q <= idx2_q[AddrW-1:0];
      clip3_q <= clip_s2;
      rgba3_q <= rgba2_q;
      z3_q    <= z2_q;
    end
  end

  // Stage 3: depth test and write-back. The store forwards a write made in
  // the same cycle as a read of that entry, so consecutive draws to one
  // pixel see each other's results.
  logic [31:0] col_rd;
  logic [15:0] dep_rd;
  logic        pass_s3;
  logic        draw_wr_s3;
  store_wr_t   wr_s3;
  out_t        out_s3;

  ztc_store #(
    .DEPTH(STORE_ENTRIES)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (free3),
    .rd_addr_i (idx2_q[AddrW-1:0]),
    .wr_i      (wr_s3),
    .wr_addr_i (addr3_q),
    .col_o     (col_rd),
    .dep_o     (dep_rd)
  );

  always_comb begin
    pass_s3    = !depth_test_q || ($signed(z3_q) >= $signed(dep_rd));
    draw_wr_s3 = (op3_q == OP_DRAW) && pass_s3;

    wr_s3.col_we = leave3 && (draw_wr_s3 || (op3_q == OP_CLEAR));
    wr_s3.dep_we = leave3 && ((draw_wr_s3 && depth_test_q) || (op3_q == OP_CLEAR));
    wr_s3.rgba   = (op3_q == OP_CLEAR) ? 32'd0 : rgba3_q;
    wr_s3.depth  = (op3_q == OP_CLEAR) ? DEPTH_CLEAR : z3_q;

    out_s3.read_rgba = (op3_q == OP_READ) ? col_rd : 32'd0;
    out_s3.painted   = draw_wr_s3;
    out_s3.clipped   = clip3_q;
  end

  // Output register.
  out_t out_data_q;

  always_ff @(posedge clk_i) begin
    if (take_out) begin
      out_data_q <= out_s3;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // A depth update never happens without the matching colour write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_s3.dep_we |-> wr_s3.col_we)
    else $error("depth store written without colour store");

  // A painted pixel is never also clipped and never carries read data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.painted) |->
      (!out_data_o.clipped && (out_data_o.read_rgba == 32'd0)))
    else $error("painted result with clipped flag or read data");

  // The input only stalls when the output is holding a result that is not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while the output can move");

  // Stores are written only by a transaction leaving the read-modify-write stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_s3.col_we |-> (v3_q && take_out && ((op3_q == OP_DRAW) || (op3_q == OP_CLEAR))))
    else $error("store write without a draw or clear in flight");
`endif

endmodule

// ----- tb/sv/tb_zbuffered_iso_tile_compositor_core.sv -----
module tb_zbuffered_iso_tile_compositor_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ztc_pkg::*;

  // Geometry of the block as instantiated (its default parameters).
  localparam int STORE_ENTRIES = 1048576;
  localparam int CELL_HALF_W   = 30;
  localparam int CELL_HALF_H   = 15;
  localparam int CELL_H        = 30;

  // The fourth command code has no function; the block must answer with zeros.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Once enough transactions have gone in, the receiver refuses results for the
  // STALL_LEN span while the sender keeps offering, so the pipeline backs up.
  localparam int STALL_AT  = 250;
  localparam int STALL_LEN = 300;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_t                   in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_t                  out_data_o;

  // Our own copy of the configuration, starting from the reset values.
  int frame_w   = 1024;
  int frame_h   = 1024;
  int map_w     = 0;
  int origin_rw = 96;
  bit ztest_on  = 1'b1;

  // Predicted contents of the frame store. Only entries that a clear has
  // touched are ever looked up.
  logic [31:0] colour_mem [int];
  logic [15:0] depth_mem  [int];

  // Stimulus bookkeeping: which entries have been cleared so far.
  bit clear_seen [int];
  int cleared_idx [$];

  in_t  pending_cmds [$];
  out_t due_results [$];
  out_t want;

  int n_queued   = 0;
  int n_accepted = 0;
  int n_errors   = 0;
  bit in_took    = 1'b0;

  int snd_idle_pct = 24;
  int rcv_idle_pct = 88;
  int stall_left   = 0;
  bit stall_done   = 1'b0;

  always #4 clk_i = ~clk_i;

  zbuffered_iso_tile_compositor_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Integer division rounding toward minus and plus infinity.
  function automatic int fdiv(int a, int b);
    return (a >= 0) ? a / b : -((-a + b - 1) / b);
  endfunction

  function automatic int cdiv(int a, int b);
    return -fdiv(-a, b);
  endfunction

  // Store entry hit by a draw under the current configuration, or -1 when the
  // pixel lands outside the frame or beyond the end of the store.
  function automatic int screen_index(in_t c);
    int col, row, lvl, ox, oy, px, py, x, y, idx;
    col = c.cell_col;
    row = c.cell_row;
    lvl = c.cell_level;
    ox  = c.tile_origin_x;
    oy  = c.tile_origin_y;
    px  = c.tile_px;
    py  = c.tile_py;
    x = col * CELL_HALF_W - ox + px;
    y = origin_rw + (row - lvl) * CELL_HALF_H - oy + py;
    if (x < 0 || x >= frame_w || y < 0 || y >= frame_h) return -1;
    idx = y * frame_w + x;
    if (idx >= STORE_ENTRIES) return -1;
    return idx;
  endfunction

  // Applies one accepted transaction to the predicted store and returns the
  // result transaction the block owes for it.
  function automatic out_t composite_pixel(in_t c);
    out_t        r;
    int          idx, row, dofs;
    logic [15:0] z;
    r = '0;
    case (c.command)
      CMD_DRAW: begin
        idx = screen_index(c);
        if (idx < 0) begin
          r.clipped = 1'b1;
        end else if (c.pixel_rgba[31:24] != 8'h00) begin
          row  = c.cell_row;
          dofs = c.depth_offset;
          // Depth is kept as 16-bit two's complement, so small rows with a
          // large offset go negative.
          z = 16'((row + 1 + map_w) * (CELL_H / 2) - dofs);
          if (!ztest_on) begin
            colour_mem[idx] = c.pixel_rgba;
            r.painted = 1'b1;
          end else if ($signed(z) >= $signed(depth_mem[idx])) begin
            colour_mem[idx] = c.pixel_rgba;
            depth_mem[idx]  = z;
            r.painted = 1'b1;
          end
        end
      end
      CMD_CLEAR, CMD_READ: begin
        idx = c.frame_index;
        if (idx >= STORE_ENTRIES) begin
          r.clipped = 1'b1;
        end else if (c.command == CMD_CLEAR) begin
          colour_mem[idx] = '0;
          depth_mem[idx]  = DEPTH_CLEAR;
        end else begin
          r.read_rgba = colour_mem[idx];
        end
      end
      default: begin
        // The unused command leaves the store alone and returns zeros.
      end
    endcase
    return r;
  endfunction

  function automatic in_t any_item(logic [1:0] cmd);
    logic [127:0] bits;
    in_t          c;
    bits = {$urandom, $urandom, $urandom, $urandom};
    c = bits[$bits(in_t)-1:0];
    c.command = cmd;
    return c;
  endfunction

  // Builds a draw with random content that lands exactly on screen pixel
  // (x, y). Column, origins and pixel offsets are solved backward from the
  // screen equations; fails when no column fits or the chosen level leaves no legal row.
  function automatic bit aim_at(int x, int y, output in_t c);
    int lo, hi, col, lvl, r, d, o, e;
    c = any_item(CMD_DRAW);
    lo = cdiv(x - 255, CELL_HALF_W);
    hi = fdiv(x + 255, CELL_HALF_W);
    if (lo < 0) lo = 0;
    if (hi > 1023) hi = 1023;
    if (lo > hi) return 1'b0;
    col = lo + $urandom_range(hi - lo, 0);
    d = x - col * CELL_HALF_W;
    o = ((d < 0) ? -d : 0) + $urandom_range(255 - ((d > 0) ? d : 0) - ((d < 0) ? -d : 0), 0);
    c.cell_col      = 10'(col);
    c.tile_origin_x = 8'(o);
    c.tile_px       = 8'(d + o);
    lvl = $urandom_range(15, 0);
    e   = y - origin_rw;
    lo  = cdiv(e - 255, CELL_HALF_H);
    hi  = fdiv(e + 255, CELL_HALF_H);
    if (lo < -lvl) lo = -lvl;
    if (hi > 1023 - lvl) hi = 1023 - lvl;
    if (lo > hi) return 1'b0;
    r = lo + $urandom_range(hi - lo, 0);
    d = e - r * CELL_HALF_H;
    o = ((d < 0) ? -d : 0) + $urandom_range(255 - ((d > 0) ? d : 0) - ((d < 0) ? -d : 0), 0);
    c.cell_level    = 4'(lvl);
    c.cell_row      = 10'(r + lvl);
    c.tile_origin_y = 8'(o);
    c.tile_py       = 8'(d + o);
    return 1'b1;
  endfunction

  function automatic void queue_cmd(in_t c, bit counts);
    pending_cmds = {pending_cmds, c};
    if (counts) n_queued++;
  endfunction

  function automatic void queue_clear(int idx);
    in_t c;
    c = any_item(CMD_CLEAR);
    c.frame_index = 20'(idx);
    queue_cmd(c, 1'b1);
    if (!clear_seen.exists(idx)) begin
      clear_seen[idx] = 1'b1;
      cleared_idx = {cleared_idx, idx};
    end
  endfunction

  function automatic void queue_read(int idx);
    in_t c;
    c = any_item(CMD_READ);
    c.frame_index = 20'(idx);
    queue_cmd(c, 1'b1);
  endfunction

  // A draw that reaches the store is preceded by a clear of its entry the
  // first time, since the store holds garbage until cleared.
  function automatic void queue_draw(in_t c);
    int idx;
    idx = screen_index(c);
    if (idx >= 0 && !clear_seen.exists(idx)) queue_clear(idx);
    queue_cmd(c, 1'b1);
  endfunction

  // Directed opening under the reset configuration: depth test outcomes on
  // one pixel, a transparent pixel, negative depths, clipping on each side of
  // the frame, field extremes, the unused command, and the store's ends.
  function automatic void queue_directed();
    in_t c;
    int  idx;
    void'(aim_at(0, 0, c));
    c.pixel_rgba   = 32'hFF00_00FF;
    c.depth_offset = 8'd100;
    queue_draw(c);
    c.pixel_rgba = 32'h80FF_FF00;
    queue_draw(c);
    c.depth_offset = 8'd101;
    c.pixel_rgba   = 32'hFFFF_FFFF;
    queue_draw(c);
    c.depth_offset = 8'd0;
    c.pixel_rgba   = 32'h0100_0000;
    queue_draw(c);
    c.pixel_rgba = 32'h00FF_FFFF;
    queue_draw(c);
    idx = screen_index(c);
    queue_read(idx);

    // Row zero with the largest offset gives a negative depth.
    c = '0;
    c.command      = CMD_DRAW;
    c.tile_px      = 8'd7;
    c.depth_offset = 8'd255;
    c.pixel_rgba   = 32'hFFFF_FFFF;
    queue_draw(c);
    c.depth_offset = 8'd254;
    queue_draw(c);

    c = '0;
    queue_draw(c);
    c = '1;
    c.command = CMD_DRAW;
    queue_draw(c);

    c = '0;
    c.command    = CMD_DRAW;
    c.pixel_rgba = 32'hFFFF_FFFF;
    c.tile_origin_x = 8'd255;
    queue_draw(c);
    c.tile_origin_x = 8'd0;
    c.cell_level    = 4'd15;
    c.tile_origin_y = 8'd255;
    queue_draw(c);
    c.cell_level    = 4'd0;
    c.tile_origin_y = 8'd0;
    c.cell_col      = 10'd1023;
    queue_draw(c);
    c.cell_col = 10'd0;
    c.cell_row = 10'd1023;
    c.tile_py  = 8'd255;
    queue_draw(c);

    c = '0;
    c.command = CMD_UNUSED;
    queue_cmd(c, 1'b0);
    c = '1;
    queue_cmd(c, 1'b0);

    queue_clear(0);
    queue_read(0);
    queue_clear(20'hFFFFF);
    queue_read(20'hFFFFF);
  endfunction

  // Random stimulus for one configuration. Most of it paints a handful of
  // hot pixels over and over so the depth test sees real contention and the
  // forwarding between back-to-back draws is exercised; the rest is random
  // draws, clears, reads and the unused command.
  function automatic void queue_random(int n);
    int  hx [$];
    int  hy [$];
    int  goal, k, t, ylo, yhi, x, y, idx;
    in_t c;
    goal = n_queued + n;
    ylo = origin_rw - 480;
    yhi = origin_rw + 1023 * CELL_HALF_H + 255;
    if (ylo < 0) ylo = 0;
    if (yhi > frame_h - 1) yhi = frame_h - 1;
    if (ylo <= yhi) begin
      repeat (80) begin
        if (hx.size() >= 6) break;
        x = $urandom_range(frame_w - 1, 0);
        y = $urandom_range(yhi, ylo);
        if (aim_at(x, y, c)) begin
          hx = {hx, x};
          hy = {hy, y};
        end
      end
    end
    while (n_queued < goal) begin
      k = $urandom_range(99, 0);
      if (k < 70 && hx.size() > 0) begin
        t = $urandom_range(hx.size() - 1, 0);
        repeat ($urandom_range(4, 1)) begin
          if (aim_at(hx[t], hy[t], c)) begin
            c.pixel_rgba[31:24] = ($urandom_range(9, 0) == 0) ? 8'h00
                                                               : (c.pixel_rgba[31:24] | 8'h01);
            queue_draw(c);
            idx = screen_index(c);
            if (idx >= 0 && $urandom_range(2, 0) == 0) queue_read(idx);
          end
        end
      end else if (k < 82) begin
        queue_draw(any_item(CMD_DRAW));
      end else if (k < 89) begin
        queue_clear($urandom_range(20'hFFFFF, 0));
      end else if (k < 96) begin
        if (cleared_idx.size() > 0) begin
          queue_read(cleared_idx[$urandom_range(cleared_idx.size() - 1, 0)]);
        end
      end else begin
        queue_cmd(any_item(CMD_UNUSED), 1'b0);
      end
    end
  endfunction

  task automatic write_reg(cfg_reg_e addr, int value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= CFG_DATA_W'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_frame(int fw, int fh, int mw, int orow, int zt);
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_HEIGHT, fh);
    write_reg(REG_MAP_WIDTH, mw);
    write_reg(REG_ORIGIN_ROW, orow);
    write_reg(REG_DEPTH_TEST, zt);
    frame_w   = fw;
    frame_h   = fh;
    map_w     = mw;
    origin_rw = orow;
    ztest_on  = zt[0];
  endtask

  // Waits until the sender has nothing left and every predicted result has
  // come back, then lets the four-stage pipeline run dry.
  task automatic settle();
    while (pending_cmds.size() > 0 || in_valid_i || due_results.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  // Sender: presents the next queued transaction at the falling edge once the
  // previous one has been taken, sometimes holding back to leave a gap.
  always @(negedge clk_i) begin
    if (!in_valid_i || in_took) begin
      if (pending_cmds.size() > 0 && $urandom_range(99, 0) >= snd_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_cmds.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long refusal started while the
  // sender still has plenty queued so that the block fills up.
  always @(negedge clk_i) begin
    if (!stall_done && n_accepted >= STALL_AT && pending_cmds.size() > 40) begin
      stall_left = STALL_LEN;
      stall_done = 1'b1;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99, 0) >= rcv_idle_pct);
    end
  end

  // Monitor: handshakes are judged at the rising edge. An accepted input
  // transaction is run through the predictor right away, in order, so the
  // predicted store sees the same sequence of writes as the block.
  always @(posedge clk_i) begin
    in_took = in_valid_i && in_ready_o;
    if (in_took) begin
      due_results = {due_results, composite_pixel(in_data_i)};
      n_accepted++;
    end
    if (out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        $error("result transaction with nothing outstanding: %p", out_data_o);
        n_errors++;
      end else begin
        want = due_results.pop_front();
        if (out_data_o.read_rgba !== want.read_rgba) begin
          $error("read_rgba: expected %h, actual %h", want.read_rgba, out_data_o.read_rgba);
          n_errors++;
        end
        if (out_data_o.painted !== want.painted) begin
          $error("painted: expected %b, actual %b", want.painted, out_data_o.painted);
          n_errors++;
        end
        if (out_data_o.clipped !== want.clipped) begin
          $error("clipped: expected %b, actual %b", want.clipped, out_data_o.clipped);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Main sequence: reset, the directed opening, then nine configurations of
  // random traffic. The first three run with a lazy receiver, the next three
  // with a lazy sender, the last three with no idling at all.
  initial begin
    int ph;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    queue_directed();
    settle();

    for (ph = 0; ph < 9; ph++) begin
      if (ph < 3) begin
        snd_idle_pct = 24;
        rcv_idle_pct = 88;
      end else if (ph < 6) begin
        snd_idle_pct = 88;
        rcv_idle_pct = 24;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      case (ph)
        0: set_frame(64, 48, 511, 200, 1);
        1: set_frame(4095, 4095, 0, 0, 1);
        2: set_frame(1, 1, 37, 0, 0);
        3: set_frame(300, 17, $urandom_range(511, 0), $urandom_range(300, 0), 0);
        4: set_frame(200, 4095, 511, 4095, 1);
        5: set_frame(32, 32, $urandom_range(511, 0), $urandom_range(100, 0), 1);
        default: set_frame($urandom_range(128, 1), $urandom_range(128, 1),
                           $urandom_range(511, 0), $urandom_range(150, 0),
                           $urandom_range(1, 0));
      endcase
      if (ph == 1) begin
        // The sender stops halfway and waits for every result before going on.
        queue_random(60);
        settle();
        queue_random(65);
      end else begin
        queue_random(125);
      end
      settle();
    end

    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
